FILE: hw/rtl/uds_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// uds_pkg - shared types and constants
// Status codes, the classified byte record and the hex digit decoder.
// ---------------------------------------------------------------------------
package uds_pkg;

	localparam int PATH_CAP = 4096;
	localparam int CNT_W    = $clog2(PATH_CAP);
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BAD    = 2'd1;
	localparam logic [1:0] ST_FORBID = 2'd2;
	localparam logic [1:0] ST_LARGE  = 2'd3;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_QUERY = 8'h3F;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_LA    = 8'h61;

	// One raw byte with its class flags, as passed from front to back
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       is_pct;
		logic       is_query;
		logic       is_nul;
		logic       hex_ok;
		logic [3:0] hex_val;
	} item_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] v);
		hex_t r;
		logic [7:0] t;
		r = '0;
		t = '0;
		if (v >= CH_ZERO && v <= CH_ZERO + 8'd9) begin
			t = v - CH_ZERO;
			r.ok = 1'b1;
		end else if (v >= CH_UA && v <= CH_UA + 8'd5) begin
			t = v - CH_UA + 8'd10;
			r.ok = 1'b1;
		end else if (v >= CH_LA && v <= CH_LA + 8'd5) begin
			t = v - CH_LA + 8'd10;
			r.ok = 1'b1;
		end
		r.val = t[3:0];
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/uds_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// uds_front - input stage
// Accept raw bytes, classify them and hold one classified beat for the queue.
// ---------------------------------------------------------------------------
module uds_front import uds_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,
	input  wire        s_tlast,
	output logic       q_valid,
	input  wire        q_ready,
	output item_t      q_item
);

	logic  valid_s1;
	item_t item_s1;
	item_t cls;
	hex_t  hx;

	always_comb begin
		hx           = hex_decode(s_tdata);
		cls.data     = s_tdata;
		cls.last     = s_tlast;
		cls.is_pct   = (s_tdata == CH_PCT);
		cls.is_query = (s_tdata == CH_QUERY);
		cls.is_nul   = (s_tdata == 8'h00);
		cls.hex_ok   = hx.ok;
		cls.hex_val  = hx.val;
	end

	assign s_tready = !valid_s1 || q_ready;
	assign q_valid  = valid_s1;
	assign q_item   = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= cls;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/uds_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// uds_queue - classified byte queue
// Small FIFO that decouples the classifier from the decode engine.
// ---------------------------------------------------------------------------
module uds_queue import uds_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   wr_valid,
	output logic  wr_ready,
	input  item_t wr_item,
	output logic  rd_valid,
	input  wire   rd_ready,
	output item_t rd_item
);

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              pop;

	assign wr_ready = (count_q != (QPTR_W+1)'(QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_item  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/uds_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// uds_back - decode engine
// Run the escape state machine and path checks, hold the result beat.
// ---------------------------------------------------------------------------
module uds_back import uds_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         q_valid,
	output logic        q_ready,
	input  item_t       q_item,
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,
	output logic        m_tlast
);

	localparam logic [2:0] PH_NORMAL = 3'd0;
	localparam logic [2:0] PH_HI     = 3'd1;
	localparam logic [2:0] PH_LO     = 3'd2;
	localparam logic [2:0] PH_STOP   = 3'd3;
	localparam logic [2:0] PH_ERR    = 3'd4;

	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(PATH_CAP - 1);
	localparam logic [23:0]      DOTDOT    = {CH_SLASH, CH_DOT, CH_DOT};

	logic [2:0]       phase_q,  phase_n;
	logic [3:0]       nib_q,    nib_n;
	logic [CNT_W-1:0] count_q,  count_n;
	logic [23:0]      recent_q, recent_n;
	logic             slash_q,  slash_n;
	logic             dotdot_q, dotdot_n;
	logic [1:0]       sticky_q, sticky_n;

	logic             emit;
	logic [7:0]       dec;
	logic [7:0]       byte_o;
	logic [1:0]       stat_o;
	logic             take;

	logic             valid_q;
	logic [15:0]      data_q;
	logic             last_q;

	assign q_ready  = !valid_q || m_tready;
	assign take     = q_valid && q_ready;
	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;

	always_comb begin
		phase_n  = phase_q;
		nib_n    = nib_q;
		count_n  = count_q;
		recent_n = recent_q;
		slash_n  = slash_q;
		dotdot_n = dotdot_q;
		sticky_n = sticky_q;
		emit     = 1'b0;
		dec      = q_item.data;

		unique case (phase_q)
			PH_NORMAL: begin
				if (q_item.is_pct)        phase_n = PH_HI;
				else if (q_item.is_query) phase_n = PH_STOP;
				else if (q_item.is_nul) begin
					phase_n  = PH_ERR;
					sticky_n = ST_BAD;
				end else emit = 1'b1;
			end
			PH_HI: begin
				if (q_item.hex_ok) begin
					nib_n   = q_item.hex_val;
					phase_n = PH_LO;
				end else begin
					phase_n  = PH_ERR;
					sticky_n = ST_BAD;
				end
			end
			PH_LO: begin
				dec = {nib_q, q_item.hex_val};
				if (!q_item.hex_ok || dec == 8'h00 || dec == CH_SLASH) begin
					phase_n  = PH_ERR;
					sticky_n = ST_BAD;
				end else begin
					phase_n = PH_NORMAL;
					emit    = 1'b1;
				end
			end
			PH_STOP, PH_ERR: begin
			end
			default: begin
			end
		endcase

		if (emit) begin
			if (count_q == '0) slash_n = (dec == CH_SLASH);
			if (recent_q == DOTDOT && dec == CH_SLASH) dotdot_n = 1'b1;
			recent_n = {recent_q[15:0], dec};
			count_n  = count_q + 1'b1;
			// a byte that brings the count to CNT_LIMIT (PATH_CAP - 1) is still emitted, and flagged too large in the same beat
			if (count_n == CNT_LIMIT) begin
				phase_n  = PH_ERR;
				sticky_n = ST_LARGE;
			end
		end

		byte_o = emit ? dec : 8'h00;
		stat_o = sticky_n;

		if (q_item.last) begin
			if (phase_n == PH_HI || phase_n == PH_LO) begin
				stat_o = ST_BAD;
			end else if (sticky_n == ST_OK && (!slash_n || dotdot_n)) begin
				stat_o = ST_FORBID;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_NORMAL;
			nib_q    <= '0;
			count_q  <= '0;
			recent_q <= '0;
			slash_q  <= 1'b0;
			dotdot_q <= 1'b0;
			sticky_q <= ST_OK;
			valid_q  <= 1'b0;
		end else begin
			if (q_ready) valid_q <= q_valid;
			if (take) begin
				if (q_item.last) begin
					// target finished: return to the idle state for the next one
					phase_q  <= PH_NORMAL;
					nib_q    <= '0;
					count_q  <= '0;
					recent_q <= '0;
					slash_q  <= 1'b0;
					dotdot_q <= 1'b0;
					sticky_q <= ST_OK;
				end else begin
					phase_q  <= phase_n;
					nib_q    <= nib_n;
					count_q  <= count_n;
					recent_q <= recent_n;
					slash_q  <= slash_n;
					dotdot_q <= dotdot_n;
					sticky_q <= sticky_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_q <= {5'b0, stat_o, emit, byte_o};
			last_q <= q_item.last;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/url_path_decode_sanitize.sv
`default_nettype none
// ---------------------------------------------------------------------------
// url_path_decode_sanitize - request target percent-decoder and path checker
// Decode a request target byte by byte and report a status for the path.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one raw target byte per beat, s_tlast on the final byte.
//   Output channel m_*: exactly one beat per input beat, in order. m_tdata
//   carries the decoded byte with a byte-valid flag and the status; the beat
//   for the final input byte has m_tlast set and carries the final status
//   (ok, bad request, forbidden, too large). Before that, status shows the
//   sticky error seen so far. Decoding stops at the first raw '?'.
//   From input beat to output beat a byte passes the classifier register,
//   the 4-entry queue and the output register of the decode engine.
//   Throughput is one byte per cycle while the receiver does not stall; the
//   decode state machine updates once per byte and nothing else limits the rate.
//   When the receiver stalls, the output beat holds, the queue fills and
//   s_tready drops once the queue and classifier register are full; no beat
//   is lost or repeated. After the final byte the engine returns to its reset
//   state and takes the next target at once.
//   Reset (arst_n low) empties the queue and output register and clears the
//   decode state; no clearing pass is needed.
// ---------------------------------------------------------------------------
module url_path_decode_sanitize import uds_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] in_byte
	input  wire         s_tlast,   // is_last
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [8] byte_valid, [10:9] status
	output logic        m_tlast    // done_res
);

	// front to queue
	logic  f_valid;
	logic  f_ready;
	item_t f_item;

	// queue to back
	logic  b_valid;
	logic  b_ready;
	item_t b_item;

	// classify each accepted byte and hold it until the queue takes it
	uds_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_valid  (f_valid),
		.q_ready  (f_ready),
		.q_item   (f_item)
	);

	// absorb output stalls so the front keeps accepting
	uds_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_item  (f_item),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_item  (b_item)
	);

	// advance the decode state machine and register the result beat
	uds_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (b_valid),
		.q_ready  (b_ready),
		.q_item   (b_item),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

FILE: hw/rtl/uds_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// uds_checker - port-level checks
// Watch the output channel of the decoder for rule breaks over time.
// ---------------------------------------------------------------------------
module uds_checker import uds_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        m_tvalid,
	input  wire        m_tready,
	input  wire [15:0] m_tdata,
	input  wire        m_tlast
);

	// a stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

	// no decoded byte means a zero byte field
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[8] |-> m_tdata[7:0] == 8'h00)
		else $error("byte field set without byte_valid");

	// forbidden is decided only on the final byte
	a_forbid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[10:9] != ST_FORBID)
		else $error("forbidden status before the final beat");

	// a byte is emitted mid-target only with no error or on reaching the cap
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[8] && !m_tlast |->
			m_tdata[10:9] == ST_OK || m_tdata[10:9] == ST_LARGE)
		else $error("byte emitted after a bad request");

endmodule

bind url_path_decode_sanitize uds_checker u_uds_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire
